FILE: src/dual_stepper_limit_seek_controller_defines.svh
// ----------------------------------------------------------------------------
// dual stepper limit seek controller: assertion macros
// shared concurrent assertion forms, clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef DUAL_STEPPER_LIMIT_SEEK_CONTROLLER_DEFINES_SVH
`define DUAL_STEPPER_LIMIT_SEEK_CONTROLLER_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define DSLSC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define DSLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/dslsc_pkg.sv
// ----------------------------------------------------------------------------
// dslsc_pkg
// types, codes and constants of the dual stepper limit seek controller
// ----------------------------------------------------------------------------
`default_nettype none

package dslsc_pkg;

	// command codes
	localparam logic [2:0] CMD_TICK     = 3'd0;
	localparam logic [2:0] CMD_MOVE     = 3'd1;
	localparam logic [2:0] CMD_SEEK_MIN = 3'd2;
	localparam logic [2:0] CMD_SEEK_MAX = 3'd3;
	localparam logic [2:0] CMD_RELEASE  = 3'd4;

	// operation modes
	localparam logic [2:0] MODE_IDLE       = 3'd0;
	localparam logic [2:0] MODE_MOVE       = 3'd1;
	localparam logic [2:0] MODE_SEEK_STEP  = 3'd2;
	localparam logic [2:0] MODE_SEEK_CHECK = 3'd3;
	localparam logic [2:0] MODE_SEEK_DEB   = 3'd4;
	localparam logic [2:0] MODE_BK_CHECK   = 3'd5;
	localparam logic [2:0] MODE_BK_DEB     = 3'd6;

	// configuration register indexes
	localparam logic [1:0] REG_STEP_PERIOD = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE    = 2'd1;
	localparam logic [1:0] REG_SEEK_MAX    = 2'd2;
	localparam logic [1:0] REG_BACKOFF_MAX = 2'd3;

	localparam logic [15:0] RST_STEP_PERIOD = 16'd2;
	localparam logic [15:0] RST_DEBOUNCE    = 16'd20;
	localparam logic [15:0] RST_SEEK_MAX    = 16'd4096;
	localparam logic [15:0] RST_BACKOFF_MAX = 16'd512;

	// phase step sizes: forward one, backward seven modulo eight
	localparam logic [2:0] PHASE_FWD = 3'd1;
	localparam logic [2:0] PHASE_REV = 3'd7;

	typedef struct packed {
		logic [15:0] step_period;
		logic [15:0] debounce;
		logic [15:0] seek_max;
		logic [15:0] backoff_max;
	} cfg_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       axis;
		logic       dir_neg;
		logic       is_seek;
		logic       to_max;
	} op_ctrl_t;

	typedef struct packed {
		logic [2:0] az_phase;
		logic [2:0] el_phase;
		logic [7:0] coils;
	} drive_t;

	typedef struct packed {
		logic [3:0] az_coils;
		logic [3:0] el_coils;
		logic       busy_res;
		logic       done_res;
		logic       success;
	} result_t;

	// half-step coil pattern, bit0 is IN1
	function automatic logic [3:0] phase_bits(input logic [2:0] ph);
		logic [3:0] b;
		unique case (ph)
			3'd0: b = 4'b0001;
			3'd1: b = 4'b0011;
			3'd2: b = 4'b0010;
			3'd3: b = 4'b0110;
			3'd4: b = 4'b0100;
			3'd5: b = 4'b1100;
			3'd6: b = 4'b1000;
			3'd7: b = 4'b1001;
			default: b = 4'b0000;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: src/dslsc_if.sv
// ----------------------------------------------------------------------------
// dslsc_in_if / dslsc_out_if
// valid/ready channels carrying command words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface dslsc_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic               axis;
	logic signed [15:0] step_count;
	logic               az_min_hit;
	logic               az_max_hit;
	logic               el_min_hit;
	logic               el_max_hit;

	modport source (
		output valid, cmd, axis, step_count, az_min_hit, az_max_hit, el_min_hit, el_max_hit,
		input  ready
	);
	modport sink (
		input  valid, cmd, axis, step_count, az_min_hit, az_max_hit, el_min_hit, el_max_hit,
		output ready
	);
endinterface

interface dslsc_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] az_coils;
	logic [3:0] el_coils;
	logic       busy_res;
	logic       done_res;
	logic       success;

	modport source (
		output valid, az_coils, el_coils, busy_res, done_res, success,
		input  ready
	);
	modport sink (
		input  valid, az_coils, el_coils, busy_res, done_res, success,
		output ready
	);
endinterface

`default_nettype wire

FILE: src/dslsc_step.sv
// ----------------------------------------------------------------------------
// dslsc_step
// next-state and result logic for one command or tick word
// ----------------------------------------------------------------------------
`default_nettype none

module dslsc_step
	import dslsc_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  cfg_t                    cfg,
	input  op_ctrl_t                cur_ctrl,
	input  drive_t                  cur_drive,
	input  logic [COUNT_WIDTH-1:0]  cur_steps,
	input  logic [COUNT_WIDTH-1:0]  cur_wait,
	input  logic [2:0]              cmd,
	input  logic                    axis,
	input  logic [15:0]             step_count,
	input  logic [3:0]              sw,
	output op_ctrl_t                nxt_ctrl,
	output drive_t                  nxt_drive,
	output logic [COUNT_WIDTH-1:0]  nxt_steps,
	output logic [COUNT_WIDTH-1:0]  nxt_wait,
	output result_t                 res
);

	logic        lim_fwd, lim_away, lim_tgt;
	logic        neg;
	logic [15:0] mag;
	logic        do_bk_check, do_bk_step, do_adv, adv_neg, do_fin, fin_ok;
	logic        done, ok;
	logic [2:0]  ph;

	// switch toward travel, switch behind travel, seek target switch
	assign lim_fwd  = sw[{cur_ctrl.axis, ~cur_ctrl.dir_neg}];
	assign lim_away = sw[{cur_ctrl.axis, cur_ctrl.dir_neg}];
	assign lim_tgt  = sw[{cur_ctrl.axis, cur_ctrl.to_max}];

	assign neg = step_count[15];
	assign mag = neg ? 16'(~step_count + 16'd1) : step_count;

	always_comb begin
		nxt_ctrl    = cur_ctrl;
		nxt_drive   = cur_drive;
		nxt_steps   = cur_steps;
		nxt_wait    = cur_wait;
		do_bk_check = 1'b0;
		do_bk_step  = 1'b0;
		do_adv      = 1'b0;
		adv_neg     = 1'b0;
		do_fin      = 1'b0;
		fin_ok      = 1'b0;
		done        = 1'b0;
		ok          = 1'b0;
		ph          = 3'd0;

		if (cmd == CMD_TICK) begin
			if (cur_ctrl.mode != MODE_IDLE) begin
				if (cur_wait != '0) begin
					nxt_wait = cur_wait - 1'b1;
				end else begin
					unique case (cur_ctrl.mode) inside
						MODE_MOVE: begin
							if (cur_steps == '0) begin
								do_fin = 1'b1;
								fin_ok = 1'b1;
							end else if (lim_fwd) begin
								nxt_steps     = COUNT_WIDTH'(cfg.backoff_max);
								nxt_ctrl.mode = MODE_BK_CHECK;
								do_bk_check   = 1'b1;
							end else begin
								do_adv  = 1'b1;
								adv_neg = cur_ctrl.dir_neg;
							end
						end
						MODE_SEEK_STEP, MODE_SEEK_CHECK, MODE_SEEK_DEB: begin
							if (cur_ctrl.mode != MODE_SEEK_STEP && lim_tgt) begin
								if (cur_ctrl.mode == MODE_SEEK_CHECK) begin
									nxt_wait      = COUNT_WIDTH'(cfg.debounce);
									nxt_ctrl.mode = MODE_SEEK_DEB;
								end else begin
									nxt_steps     = COUNT_WIDTH'(cfg.backoff_max);
									nxt_ctrl.mode = MODE_BK_CHECK;
									do_bk_check   = 1'b1;
								end
							end else if (cur_steps == '0) begin
								// search exhausted
								do_fin = 1'b1;
							end else begin
								do_adv        = 1'b1;
								adv_neg       = cur_ctrl.dir_neg;
								nxt_ctrl.mode = MODE_SEEK_CHECK;
							end
						end
						MODE_BK_CHECK: do_bk_check = 1'b1;
						MODE_BK_DEB: begin
							if (!lim_fwd) begin
								do_fin = 1'b1;
								fin_ok = cur_ctrl.is_seek;
							end else begin
								do_bk_step = 1'b1;
							end
						end
						default: nxt_ctrl.mode = MODE_IDLE;
					endcase
				end
			end
		end else if (cur_ctrl.mode == MODE_IDLE) begin
			case (cmd) inside
				CMD_MOVE: begin
					nxt_ctrl.axis    = axis;
					nxt_ctrl.dir_neg = neg;
					nxt_ctrl.is_seek = 1'b0;
					nxt_ctrl.to_max  = 1'b0;
					nxt_steps        = COUNT_WIDTH'(mag);
					nxt_wait         = '0;
					if (COUNT_WIDTH'(mag) == '0) begin
						do_fin = 1'b1;
						fin_ok = 1'b1;
					end else begin
						nxt_ctrl.mode = MODE_MOVE;
					end
				end
				CMD_SEEK_MIN, CMD_SEEK_MAX: begin
					if (step_count == 16'd0) begin
						// zero seek only reports the target switch
						done = 1'b1;
						ok   = sw[{axis, cmd == CMD_SEEK_MAX}];
					end else begin
						nxt_ctrl.axis    = axis;
						nxt_ctrl.dir_neg = neg;
						nxt_ctrl.is_seek = 1'b1;
						nxt_ctrl.to_max  = (cmd == CMD_SEEK_MAX);
						nxt_steps        = COUNT_WIDTH'(cfg.seek_max);
						nxt_wait         = '0;
						nxt_ctrl.mode    = MODE_SEEK_STEP;
					end
				end
				CMD_RELEASE: nxt_drive.coils = 8'h00;
				default: ;
			endcase
		end

		// back-off check: release axis, then end, debounce or step away
		if (do_bk_check) begin
			if (cur_ctrl.axis) nxt_drive.coils[7:4] = 4'h0;
			else               nxt_drive.coils[3:0] = 4'h0;
			if (nxt_steps == '0) begin
				do_fin = 1'b1;
				fin_ok = cur_ctrl.is_seek;
			end else if (!lim_fwd) begin
				nxt_wait      = COUNT_WIDTH'(cfg.debounce);
				nxt_ctrl.mode = MODE_BK_DEB;
			end else begin
				do_bk_step = 1'b1;
			end
		end

		// step away, aborts when the opposite switch is active too
		if (do_bk_step) begin
			if (lim_away) begin
				do_fin = 1'b1;
				fin_ok = cur_ctrl.is_seek;
			end else begin
				do_adv        = 1'b1;
				adv_neg       = ~cur_ctrl.dir_neg;
				nxt_ctrl.mode = MODE_BK_CHECK;
			end
		end

		if (do_adv) begin
			ph = nxt_ctrl.axis ? nxt_drive.el_phase : nxt_drive.az_phase;
			ph = ph + (adv_neg ? PHASE_REV : PHASE_FWD);
			if (nxt_ctrl.axis) begin
				nxt_drive.el_phase    = ph;
				nxt_drive.coils[7:4]  = phase_bits(ph);
			end else begin
				nxt_drive.az_phase    = ph;
				nxt_drive.coils[3:0]  = phase_bits(ph);
			end
			if (nxt_steps != '0) nxt_steps = nxt_steps - 1'b1;
			nxt_wait = COUNT_WIDTH'(cfg.step_period);
		end

		if (do_fin) begin
			if (nxt_ctrl.axis) nxt_drive.coils[7:4] = 4'h0;
			else               nxt_drive.coils[3:0] = 4'h0;
			nxt_ctrl.mode = MODE_IDLE;
			nxt_wait      = '0;
			done          = 1'b1;
			ok            = fin_ok;
		end
	end

	assign res.az_coils = nxt_drive.coils[3:0];
	assign res.el_coils = nxt_drive.coils[7:4];
	assign res.busy_res = (nxt_ctrl.mode != MODE_IDLE);
	assign res.done_res = done;
	assign res.success  = done & ok;

endmodule

`default_nettype wire

FILE: src/dslsc_outbuf.sv
// ----------------------------------------------------------------------------
// dslsc_outbuf
// two-entry output buffer: result register plus skid register
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_stepper_limit_seek_controller_defines.svh"

module dslsc_outbuf
	import dslsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    main_valid_q, skid_valid_q;
	result_t main_q, skid_q;
	logic    in_fire;

	assign in_ready  = ~skid_valid_q;
	assign in_fire   = in_valid & in_ready;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !main_valid_q) begin
			main_valid_q <= skid_valid_q | in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !main_valid_q) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_fire) begin
			skid_q <= in_data;
		end
	end

	`DSLSC_ASSERT_SAME(a_skid_behind_main, skid_valid_q, main_valid_q,
		"skid word held with empty result register")
	`DSLSC_ASSERT_NEXT(a_stall_holds, main_valid_q && !out_ready,
		main_valid_q && $stable(main_q), "stalled result word changed")
	`DSLSC_ASSERT_NEXT(a_skid_drains, skid_valid_q && out_ready, !skid_valid_q,
		"skid word kept after result word taken")

endmodule

`default_nettype wire

FILE: src/dual_stepper_limit_seek_controller.sv
// ----------------------------------------------------------------------------
// dual_stepper_limit_seek_controller
// half-step drive of two four-coil steppers with limit seek and back-off
// ----------------------------------------------------------------------------
// Usage:
//   item   : command or tick word (cmd, axis, step_count) plus the four limit
//            switch levels, valid/ready, taken when both are high
//   result : one word per item: coil bits of both axes, busy, done, success
//   cfg_*  : register port, written by user only while block is idle, unchecked
// Each tick advances the running operation by one count or one check;
// commands other than tick are ignored while busy.
// Each item's result word is registered in the result or skid register.
// Throughput: one item per cycle while item.ready is high, the operation state
// register feeding a single pass of next-state logic into the output buffer.
// A two-word output buffer lets one more item in while a result is stalled;
// item.ready drops only when both words are held.
// Reset: both phases zero, coils released, no operation running, the
// registers at their defaults (period 2, debounce 20, seek 4096, back-off 512).
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_stepper_limit_seek_controller_defines.svh"

module dual_stepper_limit_seek_controller
	import dslsc_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	dslsc_in_if.sink    item,
	dslsc_out_if.source result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t                   cfg_q;
	op_ctrl_t               ctrl_q, nxt_ctrl;
	drive_t                 drive_q, nxt_drive;
	logic [COUNT_WIDTH-1:0] steps_q, wait_q, nxt_steps, nxt_wait;
	result_t                step_res, out_data;
	logic                   in_ready, item_fire;

	assign item.ready = in_ready;
	assign item_fire  = item.valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_period <= RST_STEP_PERIOD;
			cfg_q.debounce    <= RST_DEBOUNCE;
			cfg_q.seek_max    <= RST_SEEK_MAX;
			cfg_q.backoff_max <= RST_BACKOFF_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_PERIOD: cfg_q.step_period <= cfg_data;
				REG_DEBOUNCE:    cfg_q.debounce    <= cfg_data;
				REG_SEEK_MAX:    cfg_q.seek_max    <= cfg_data;
				REG_BACKOFF_MAX: cfg_q.backoff_max <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= '{mode: MODE_IDLE, default: '0};
			drive_q <= '0;
			steps_q <= '0;
			wait_q  <= '0;
		end else if (item_fire) begin
			ctrl_q  <= nxt_ctrl;
			drive_q <= nxt_drive;
			steps_q <= nxt_steps;
			wait_q  <= nxt_wait;
		end
	end

	dslsc_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.cfg        (cfg_q),
		.cur_ctrl   (ctrl_q),
		.cur_drive  (drive_q),
		.cur_steps  (steps_q),
		.cur_wait   (wait_q),
		.cmd        (item.cmd),
		.axis       (item.axis),
		.step_count (item.step_count),
		.sw         ({item.el_max_hit, item.el_min_hit, item.az_max_hit, item.az_min_hit}),
		.nxt_ctrl   (nxt_ctrl),
		.nxt_drive  (nxt_drive),
		.nxt_steps  (nxt_steps),
		.nxt_wait   (nxt_wait),
		.res        (step_res)
	);

	dslsc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (in_ready),
		.in_data   (step_res),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (out_data)
	);

	assign result.az_coils = out_data.az_coils;
	assign result.el_coils = out_data.el_coils;
	assign result.busy_res = out_data.busy_res;
	assign result.done_res = out_data.done_res;
	assign result.success  = out_data.success;

	`DSLSC_ASSERT_NEXT(a_idle_tick_stays, item_fire && item.cmd == CMD_TICK &&
		ctrl_q.mode == MODE_IDLE, ctrl_q.mode == MODE_IDLE, "tick started an operation")
	`DSLSC_ASSERT_NEXT(a_wait_holds_mode, item_fire && item.cmd == CMD_TICK &&
		ctrl_q.mode != MODE_IDLE && wait_q != '0,
		ctrl_q.mode == $past(ctrl_q.mode) && steps_q == $past(steps_q),
		"operation advanced while waiting")
	`DSLSC_ASSERT_SAME(a_done_not_busy, result.valid && result.done_res,
		!result.busy_res, "finished word still reports busy")

endmodule

`default_nettype wire
